/* hw/rtl/plist_pkg.sv */
// Shared types and codes for the positional list engine.
// No dependencies; every other file of the block imports this package.
package plist_pkg;

    localparam int VAL_W = 32;
    localparam int POS_W = 8;
    localparam int LEN_W = 6;

    localparam logic [2:0] KIND_APPEND = 3'd0;
    localparam logic [2:0] KIND_INSERT = 3'd1;
    localparam logic [2:0] KIND_DELETE = 3'd2;
    localparam logic [2:0] KIND_FWD    = 3'd3;
    localparam logic [2:0] KIND_BWD    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic                    valid;
        logic signed [VAL_W-1:0] value;
        logic [1:0]              status;
        logic                    last;
        logic [LEN_W-1:0]        length;
    } emit_t;

endpackage

/* hw/rtl/plist_store.sv */
// Element store of the list: one write port and one read port with registered read data.
// Uses plist_pkg for the element width.
module plist_store
    import plist_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic                    clk,
    input  logic                    we,
    input  logic [AW-1:0]           waddr,
    input  logic signed [VAL_W-1:0] wdata,
    input  logic                    re,
    input  logic [AW-1:0]           raddr,
    output logic signed [VAL_W-1:0] rdata
);

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/plist_ctrl.sv */
// Sequencer of the list engine: decodes one operation, steps a shared address cursor
// through the store to shift or dump entries, and hands result words out. Uses plist_pkg.
module plist_ctrl
    import plist_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              kind,
    input  logic signed [VAL_W-1:0] value,
    input  logic [POS_W-1:0]        position,
    input  logic                    slot_free,
    output emit_t                   emit,
    output logic                    mem_we,
    output logic [AW-1:0]           mem_waddr,
    output logic signed [VAL_W-1:0] mem_wdata,
    output logic                    mem_re,
    output logic [AW-1:0]           mem_raddr,
    input  logic signed [VAL_W-1:0] mem_rdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_DUMP_RD,
        S_DUMP_EM,
        S_RESULT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [CW-1:0]           left_reg, left_next;
    logic [AW-1:0]           cur_reg, cur_next;
    logic [AW-1:0]           end_reg, end_next;
    logic [AW-1:0]           lat_reg, lat_next;
    logic [AW-1:0]           idx_reg, idx_next;
    logic                    dec_reg, dec_next;
    logic                    more_reg, more_next;
    logic                    pend_reg, pend_next;
    logic [1:0]              st_reg, st_next;
    logic signed [VAL_W-1:0] val_reg, val_next;

    logic [POS_W:0]          pos9;
    logic [POS_W:0]          cnt9;
    logic [AW-1:0]           pick;
    logic                    full;
    logic [AW-1:0]           cur_step;
    logic [LEN_W-1:0]        len_now;

    assign pos9     = {1'b0, position};
    assign cnt9     = (POS_W + 1)'(count_reg);
    assign full     = (count_reg == CW'(DEPTH));
    assign cur_step = dec_reg ? (cur_reg - AW'(1)) : (cur_reg + AW'(1));
    assign len_now  = LEN_W'(count_reg);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        cur_next   = cur_reg;
        end_next   = end_reg;
        lat_next   = lat_reg;
        idx_next   = idx_reg;
        dec_next   = dec_reg;
        more_next  = more_reg;
        pend_next  = pend_reg;
        st_next    = st_reg;
        val_next   = val_reg;
        pick       = '0;
        mem_we     = 1'b0;
        mem_waddr  = dec_reg ? (lat_reg + AW'(1)) : (lat_reg - AW'(1));
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = cur_reg;
        emit       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = value;
                    st_next  = ST_OK;
                    case (kind)
                        KIND_APPEND:
                        begin
                            if (full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                idx_next   = AW'(count_reg);
                                state_next = S_PUT;
                            end
                        end
                        KIND_INSERT:
                        begin
                            if (full)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_RESULT;
                            end
                            else if (pos9 > cnt9 + (POS_W + 1)'(1) && count_reg != '0)
                            begin
                                st_next    = ST_INVALID;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                if (count_reg == '0 || position == POS_W'(1))
                                begin
                                    pick = '0;
                                end
                                else if (position == '0)
                                begin
                                    pick = AW'(1);
                                end
                                else
                                begin
                                    pick = AW'(pos9 - (POS_W + 1)'(1));
                                end
                                idx_next = pick;
                                if ((POS_W + 1)'(pick) == cnt9)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    cur_next   = AW'(count_reg - CW'(1));
                                    end_next   = pick;
                                    dec_next   = 1'b1;
                                    more_next  = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        KIND_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_RESULT;
                            end
                            else if (pos9 > cnt9)
                            begin
                                st_next    = ST_INVALID;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                if (position <= POS_W'(1))
                                begin
                                    pick = '0;
                                end
                                else
                                begin
                                    pick = AW'(pos9 - (POS_W + 1)'(1));
                                end
                                if ((POS_W + 1)'(pick) == cnt9 - (POS_W + 1)'(1))
                                begin
                                    count_next = count_reg - CW'(1);
                                    state_next = S_RESULT;
                                end
                                else
                                begin
                                    cur_next   = pick + AW'(1);
                                    end_next   = AW'(count_reg - CW'(1));
                                    dec_next   = 1'b0;
                                    more_next  = 1'b1;
                                    pend_next  = 1'b0;
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        KIND_FWD, KIND_BWD:
                        begin
                            if (count_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_RESULT;
                            end
                            else
                            begin
                                dec_next   = (kind == KIND_BWD);
                                cur_next   = (kind == KIND_BWD) ?
                                             AW'(count_reg - CW'(1)) : '0;
                                left_next  = count_reg;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                end
                if (more_reg)
                begin
                    mem_re    = 1'b1;
                    lat_next  = cur_reg;
                    pend_next = 1'b1;
                    if (cur_reg == end_reg)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        cur_next = cur_step;
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (dec_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_RESULT;
                    end
                end
            end
            S_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESULT;
            end
            S_DUMP_RD:
            begin
                mem_re     = 1'b1;
                cur_next   = cur_step;
                left_next  = left_reg - CW'(1);
                state_next = S_DUMP_EM;
            end
            S_DUMP_EM:
            begin
                if (slot_free)
                begin
                    emit.valid  = 1'b1;
                    emit.value  = mem_rdata;
                    emit.status = ST_OK;
                    emit.last   = (left_reg == '0);
                    emit.length = len_now;
                    if (left_reg != '0)
                    begin
                        mem_re    = 1'b1;
                        cur_next  = cur_step;
                        left_next = left_reg - CW'(1);
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    emit.valid  = 1'b1;
                    emit.value  = '0;
                    emit.status = st_reg;
                    emit.last   = 1'b1;
                    emit.length = len_now;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            more_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            more_reg  <= more_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg <= left_next;
        cur_reg  <= cur_next;
        end_reg  <= end_next;
        lat_reg  <= lat_next;
        idx_reg  <= idx_next;
        dec_reg  <= dec_next;
        st_reg   <= st_next;
        val_reg  <= val_next;
    end

endmodule

/* hw/rtl/positional_list_engine.sv */
// Top level of the positional list engine: sequencer, element store and output register.
// Depends on plist_pkg, plist_store and plist_ctrl.
//
//   channel | handshake          | payload
//   input   | in_valid, in_ready | kind, value, position
//   output  | out_valid, out_ready| item_value, status, last, length
//
// One operation is taken at a time; in_ready is high only while the sequencer is idle.
// Append writes straight to the store; insert and delete first shift any entries behind the position.
// A dump of n elements gives one word per cycle once started, while out_ready holds.
// Shifts move one entry at a time through the single read and write port of the element store.
// Reset clears the element count; store contents need no clearing.
// A stalled output holds its word and the sequencer waits until the register frees.
module positional_list_engine
    import plist_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              kind,
    input  logic signed [VAL_W-1:0] value,
    input  logic [POS_W-1:0]        position,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] item_value,
    output logic [1:0]              status,
    output logic                    last,
    output logic [LEN_W-1:0]        length
);

    localparam int AW = $clog2(DEPTH);

    emit_t                   emit;
    emit_t                   out_reg;
    logic                    slot_free;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [VAL_W-1:0] mem_rdata;

    assign slot_free = !out_reg.valid || out_ready;

    plist_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .value     (value),
        .position  (position),
        .slot_free (slot_free),
        .emit      (emit),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    plist_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (emit.valid)
        begin
            out_reg <= emit;
        end
        else if (out_ready)
        begin
            out_reg.valid <= 1'b0;
        end
    end

    assign out_valid  = out_reg.valid;
    assign item_value = out_reg.value;
    assign status     = out_reg.status;
    assign last       = out_reg.last;
    assign length     = out_reg.length;

endmodule

/* hw/rtl/plist_checker.sv */
// Port-level checks for the positional list engine, bound to the top level.
// Depends on plist_pkg and positional_list_engine.
module plist_port_checks
    import plist_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [VAL_W-1:0] item_value,
    input logic [1:0]              status,
    input logic                    last
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready stayed high after an accepted word");

    a_error_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last)
        else $error("non-ok status on a word that is not last");

    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && item_value != '0 |-> status == ST_OK)
        else $error("nonzero element value with an error status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(item_value) && $stable(last))
        else $error("stalled output word changed");

endmodule

bind positional_list_engine plist_port_checks u_plist_port_checks (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .item_value (item_value),
    .status     (status),
    .last       (last)
);
